// ----- src/csp_pkg.sv -----
package csp_pkg;

    localparam int VFB      = 16;
    localparam int TFB      = 16;
    localparam int TEN_FB   = 16;
    localparam int PT_W     = 32;
    localparam int NUM_PT   = 4;
    localparam int T_W      = TFB + 1;
    localparam int OUT_W    = 40;
    localparam int UP_W     = PT_W + 4;
    localparam int SUM_W    = UP_W + 4;
    localparam int PROD_W   = 64;
    localparam int COEF_W   = 63 - TFB;
    localparam int TURN_SH  = 16 + VFB;
    localparam int TENSION_W = 16;

    localparam int IN_TDATA_W  = ((NUM_PT * PT_W + T_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;
    localparam int USER_LINEAR = 0;
    localparam int USER_WRAP   = 1;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W   = APB_AW - REG_IDX_LSB;
    localparam logic [REG_IDX_W-1:0] REG_TENSION = '0;
    localparam logic [TENSION_W-1:0] TENSION_RST = 16'd36700;

    typedef logic signed [PT_W-1:0]   point_t;
    typedef logic signed [UP_W-1:0]   upt_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OUT_W-1:0]  out_t;
    typedef logic [T_W-1:0]           tpar_t;

    localparam prod_t INNER_LIM = 64'sd1 <<< (61 - TFB);
    localparam prod_t OUT_MAX   = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam prod_t OUT_MIN   = -(64'sd1 <<< (OUT_W - 1));
    localparam prod_t HALF_TURN = 64'sd32768 <<< VFB;

    // Rounds half toward plus infinity while dropping n fraction bits.
    function automatic prod_t rnd_shift(input prod_t x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic coef_t sat_inner(input prod_t x);
        prod_t r;
        r = x;
        if (x > INNER_LIM) begin
            r = INNER_LIM;
        end else if (x < -INNER_LIM) begin
            r = -INNER_LIM;
        end
        return r[COEF_W-1:0];
    endfunction

    function automatic out_t sat_out(input prod_t x);
        prod_t r;
        r = x;
        if (x > OUT_MAX) begin
            r = OUT_MAX;
        end else if (x < OUT_MIN) begin
            r = OUT_MIN;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic prod_t mul_t(input coef_t a, input tpar_t t);
        prod_t ae;
        prod_t te;
        ae = prod_t'(a);
        te = prod_t'({1'b0, t});
        return ae * te;
    endfunction

endpackage

// ----- src/cardinal_spline_sample.sv -----
// Throughput: one item per clock while m_tready does not hold the output;
// ten register stages, holding the multipliers and the wide adds with
// saturation, set the depth.
// Each stage carries a valid bit and advances when the next stage is free, so
// back-pressure fills bubbles first and never drops or repeats an item.
// Reset (aresetn low, synchronous) empties the pipeline and sets tension to 36700.
module cardinal_spline_sample (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: point_prev, point_cur, point_next, point_after, t, zero fill.
    input  logic [csp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: linear, angle_wrap.
    input  logic [csp_pkg::IN_TUSER_W-1:0]     s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: value, tangent.
    output logic [csp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [csp_pkg::APB_AW-1:0]         paddr,
    input  logic [csp_pkg::APB_DW-1:0]         pwdata,
    output logic [csp_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    import csp_pkg::*;

    localparam int NS = 10;

    logic [TENSION_W-1:0] tension_reg;
    logic [NS:1]          vld_reg;
    logic [NS:1]          vld_next;
    logic [NS:1]          adv;

    point_t              pt_in [NUM_PT];
    tpar_t               t_in;
    prod_t               dif [NUM_PT-1];
    logic [NUM_PT-2:0]   up;
    logic [NUM_PT-2:0]   dn;
    logic signed [2:0]   turns [NUM_PT];
    upt_t                s1_pt_next [NUM_PT];

    upt_t  s1_pt_reg [NUM_PT];
    tpar_t s1_t_reg;
    logic  s1_lin_reg;

    sum_t  s2_a0_next, s2_a1_next, s2_a2_next, s2_l_next;
    sum_t  s2_a0_reg, s2_a1_reg, s2_a2_reg, s2_l_reg;
    upt_t  s2_p1_reg;
    tpar_t s2_t_reg;
    logic  s2_lin_reg;

    prod_t s3_m0_next, s3_m1_next, s3_m2_next;
    prod_t s3_m0_reg, s3_m1_reg, s3_m2_reg;
    sum_t  s3_l_reg;
    upt_t  s3_p1_reg;
    tpar_t s3_t_reg;
    logic  s3_lin_reg;

    coef_t s4_c0_reg, s4_c1_reg, s4_c2_reg, s4_d_reg;
    upt_t  s4_p1_reg;
    tpar_t s4_t_reg;
    logic  s4_lin_reg;

    prod_t s5_vp_reg;
    coef_t s5_k3_reg, s5_c0_reg, s5_c1_reg, s5_d_reg;
    upt_t  s5_p1_reg;
    tpar_t s5_t_reg;
    logic  s5_lin_reg;

    coef_t s6_va_reg, s6_c0_reg, s6_c1_reg, s6_d_reg;
    prod_t s6_tp_reg;
    upt_t  s6_p1_reg;
    tpar_t s6_t_reg;
    logic  s6_lin_reg;

    prod_t s7_vp_reg;
    coef_t s7_ta_reg, s7_c0_reg, s7_d_reg;
    upt_t  s7_p1_reg;
    tpar_t s7_t_reg;
    logic  s7_lin_reg;

    coef_t s8_va_reg, s8_c0_reg, s8_d_reg;
    prod_t s8_tp_reg;
    upt_t  s8_p1_reg;
    tpar_t s8_t_reg;
    logic  s8_lin_reg;

    prod_t s9_vp_reg;
    out_t  s9_tan_reg;
    upt_t  s9_p1_reg;

    out_t  s10_val_reg;
    out_t  s10_tan_reg;

    coef_t s9_mul_src;

    // Handshake and pipeline control.
    always_comb begin
        adv[NS] = ~vld_reg[NS] | m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            adv[k] = ~vld_reg[k] | adv[k + 1];
        end
        vld_next = {vld_reg[NS-1:1], s_tvalid};
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[NS];
    assign m_tdata  = {s10_tan_reg, s10_val_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            tension_reg <= TENSION_RST;
        end else begin
            vld_reg <= (adv & vld_next) | (~adv & vld_reg);
            if (psel && penable && pwrite && pready
                    && paddr[APB_AW-1:REG_IDX_LSB] == REG_TENSION) begin
                tension_reg <= pwdata[TENSION_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:REG_IDX_LSB] == REG_TENSION)
                  ? APB_DW'(tension_reg) : '0;

    // Angle unwrap: each step offset only depends on the original difference.
    always_comb begin
        for (int i = 0; i < NUM_PT; i++) begin
            pt_in[i] = s_tdata[i*PT_W +: PT_W];
        end
        t_in = s_tdata[NUM_PT*PT_W +: T_W];
        for (int k = 0; k < NUM_PT - 1; k++) begin
            dif[k] = prod_t'(pt_in[k + 1]) - prod_t'(pt_in[k]);
            up[k]  = s_tuser[USER_WRAP] && (dif[k] > HALF_TURN);
            dn[k]  = s_tuser[USER_WRAP] && (dif[k] < -HALF_TURN);
        end
        turns[0] = 3'sd0;
        for (int j = 1; j < NUM_PT; j++) begin
            turns[j] = turns[j - 1] + (dn[j - 1] ? 3'sd1 : 3'sd0)
                                    - (up[j - 1] ? 3'sd1 : 3'sd0);
        end
        for (int j = 0; j < NUM_PT; j++) begin
            s1_pt_next[j] = upt_t'(pt_in[j]) + (upt_t'(turns[j]) <<< TURN_SH);
        end
    end

    always_comb begin
        s2_a0_next = sum_t'(s1_pt_reg[2]) - sum_t'(s1_pt_reg[0]);
        s2_a1_next = (sum_t'(s1_pt_reg[0]) <<< 1) + sum_t'(s1_pt_reg[1])
                   - (sum_t'(s1_pt_reg[2]) <<< 1) - sum_t'(s1_pt_reg[3]);
        s2_a2_next = sum_t'(s1_pt_reg[2]) + sum_t'(s1_pt_reg[3])
                   - sum_t'(s1_pt_reg[0]) - sum_t'(s1_pt_reg[1]);
        s2_l_next  = sum_t'(s1_pt_reg[2]) - sum_t'(s1_pt_reg[1]);
    end

    always_comb begin
        s3_m0_next = prod_t'({1'b0, tension_reg}) * prod_t'(s2_a0_reg);
        s3_m1_next = prod_t'({1'b0, tension_reg}) * prod_t'(s2_a1_reg)
                   + ((prod_t'(s2_l_reg) + (prod_t'(s2_l_reg) <<< 1)) <<< TEN_FB);
        s3_m2_next = prod_t'({1'b0, tension_reg}) * prod_t'(s2_a2_reg)
                   - (prod_t'(s2_l_reg) <<< (TEN_FB + 1));
    end

    assign s9_mul_src = s8_lin_reg ? s8_d_reg : s8_va_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_pt_reg  <= s1_pt_next;
            s1_t_reg   <= t_in;
            s1_lin_reg <= s_tuser[USER_LINEAR];
        end
        if (adv[2]) begin
            s2_a0_reg  <= s2_a0_next;
            s2_a1_reg  <= s2_a1_next;
            s2_a2_reg  <= s2_a2_next;
            s2_l_reg   <= s2_l_next;
            s2_p1_reg  <= s1_pt_reg[1];
            s2_t_reg   <= s1_t_reg;
            s2_lin_reg <= s1_lin_reg;
        end
        if (adv[3]) begin
            s3_m0_reg  <= s3_m0_next;
            s3_m1_reg  <= s3_m1_next;
            s3_m2_reg  <= s3_m2_next;
            s3_l_reg   <= s2_l_reg;
            s3_p1_reg  <= s2_p1_reg;
            s3_t_reg   <= s2_t_reg;
            s3_lin_reg <= s2_lin_reg;
        end
        if (adv[4]) begin
            s4_c0_reg  <= sat_inner(rnd_shift(s3_m0_reg, TEN_FB));
            s4_c1_reg  <= sat_inner(rnd_shift(s3_m1_reg, TEN_FB));
            s4_c2_reg  <= sat_inner(rnd_shift(s3_m2_reg, TEN_FB));
            s4_d_reg   <= sat_inner(prod_t'(s3_l_reg));
            s4_p1_reg  <= s3_p1_reg;
            s4_t_reg   <= s3_t_reg;
            s4_lin_reg <= s3_lin_reg;
        end
        if (adv[5]) begin
            s5_vp_reg  <= mul_t(s4_c2_reg, s4_t_reg);
            s5_k3_reg  <= sat_inner(prod_t'(s4_c2_reg) + (prod_t'(s4_c2_reg) <<< 1));
            s5_c0_reg  <= s4_c0_reg;
            s5_c1_reg  <= s4_c1_reg;
            s5_d_reg   <= s4_d_reg;
            s5_p1_reg  <= s4_p1_reg;
            s5_t_reg   <= s4_t_reg;
            s5_lin_reg <= s4_lin_reg;
        end
        if (adv[6]) begin
            s6_va_reg  <= sat_inner(rnd_shift(s5_vp_reg, TFB) + prod_t'(s5_c1_reg));
            s6_tp_reg  <= mul_t(s5_k3_reg, s5_t_reg);
            s6_c0_reg  <= s5_c0_reg;
            s6_c1_reg  <= s5_c1_reg;
            s6_d_reg   <= s5_d_reg;
            s6_p1_reg  <= s5_p1_reg;
            s6_t_reg   <= s5_t_reg;
            s6_lin_reg <= s5_lin_reg;
        end
        if (adv[7]) begin
            s7_vp_reg  <= mul_t(s6_va_reg, s6_t_reg);
            s7_ta_reg  <= sat_inner(rnd_shift(s6_tp_reg, TFB)
                                    + (prod_t'(s6_c1_reg) <<< 1));
            s7_c0_reg  <= s6_c0_reg;
            s7_d_reg   <= s6_d_reg;
            s7_p1_reg  <= s6_p1_reg;
            s7_t_reg   <= s6_t_reg;
            s7_lin_reg <= s6_lin_reg;
        end
        if (adv[8]) begin
            s8_va_reg  <= sat_inner(rnd_shift(s7_vp_reg, TFB) + prod_t'(s7_c0_reg));
            s8_tp_reg  <= mul_t(s7_ta_reg, s7_t_reg);
            s8_c0_reg  <= s7_c0_reg;
            s8_d_reg   <= s7_d_reg;
            s8_p1_reg  <= s7_p1_reg;
            s8_t_reg   <= s7_t_reg;
            s8_lin_reg <= s7_lin_reg;
        end
        if (adv[9]) begin
            s9_vp_reg  <= mul_t(s9_mul_src, s8_t_reg);
            s9_tan_reg <= s8_lin_reg ? sat_out(prod_t'(s8_d_reg))
                        : sat_out(rnd_shift(s8_tp_reg, TFB) + prod_t'(s8_c0_reg));
            s9_p1_reg  <= s8_p1_reg;
        end
        if (adv[10]) begin
            s10_val_reg <= sat_out(rnd_shift(s9_vp_reg, TFB) + prod_t'(s9_p1_reg));
            s10_tan_reg <= s9_tan_reg;
        end
    end

endmodule

// ----- tb/cardinal_spline_sample_tb.sv -----
`timescale 1ns / 100ps

module cardinal_spline_sample_tb;

    localparam int          PIPE_LATENCY = 10;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_PER_PHASE = 180;
    localparam int          NUM_PHASES   = 6;
    localparam longint      ACC_LIM   = 64'sd1 <<< (61 - csp_pkg::TFB);
    localparam longint      OUT_HI    = (64'sd1 <<< 39) - 64'sd1;
    localparam longint      OUT_LO    = -(64'sd1 <<< 39);
    localparam longint      TURN_HALF = 64'sd32768 <<< csp_pkg::VFB;
    localparam longint      TURN_FULL = 64'sd65536 <<< csp_pkg::VFB;
    localparam longint      UNIT_TEN  = 64'sd1 <<< csp_pkg::TEN_FB;
    localparam logic [31:0] PT_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] PT_MIN    = 32'h8000_0000;
    localparam logic [csp_pkg::APB_AW-1:0] ADDR_TENSION =
        csp_pkg::APB_AW'(csp_pkg::REG_TENSION) << csp_pkg::REG_IDX_LSB;
    localparam logic [csp_pkg::APB_AW-1:0] ADDR_UNMAPPED = ADDR_TENSION + 3'd4;

    typedef struct {
        logic signed [31:0] prev_pt;
        logic signed [31:0] cur_pt;
        logic signed [31:0] next_pt;
        logic signed [31:0] after_pt;
        logic [16:0]        t;
        logic               linear;
        logic               angle_wrap;
    } sample_req_t;

    typedef struct packed {
        logic [39:0] value;
        logic [39:0] tangent;
    } spline_res_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic [csp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [csp_pkg::IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [csp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [csp_pkg::APB_AW-1:0]      paddr    = '0;
    logic [csp_pkg::APB_DW-1:0]      pwdata   = '0;
    logic [csp_pkg::APB_DW-1:0]      prdata;
    logic                            pready;

    sample_req_t pending_samples[$];
    spline_res_t expected_curve[$];
    logic [15:0] tension_model = csp_pkg::TENSION_RST;
    logic        req_taken = 1'b0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          err_count = 0;
    int          cycle_count = 0;

    cardinal_spline_sample dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint shift_round(input longint x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip_acc(input longint x);
        if (x > ACC_LIM) begin
            return ACC_LIM;
        end else if (x < -ACC_LIM) begin
            return -ACC_LIM;
        end
        return x;
    endfunction

    function automatic logic [39:0] clip_out(input longint x);
        longint r;
        r = x;
        if (x > OUT_HI) begin
            r = OUT_HI;
        end else if (x < OUT_LO) begin
            r = OUT_LO;
        end
        return r[39:0];
    endfunction

    function automatic longint scale_t(input longint a, input longint tt);
        return shift_round(a * tt, csp_pkg::TFB);
    endfunction

    function automatic spline_res_t eval_segment(input sample_req_t r, input logic [15:0] ten);
        longint      pt [4];
        longint      s, tt, d, c0, c1, c2, acc, val, tng;
        spline_res_t res;
        pt[0] = longint'(r.prev_pt);
        pt[1] = longint'(r.cur_pt);
        pt[2] = longint'(r.next_pt);
        pt[3] = longint'(r.after_pt);
        s  = longint'(ten);
        tt = longint'(r.t);
        if (r.angle_wrap) begin
            for (int i = 0; i < 3; i++) begin
                d = pt[i+1] - pt[i];
                if (d > TURN_HALF) begin
                    for (int j = i + 1; j < 4; j++) pt[j] -= TURN_FULL;
                end else if (d < -TURN_HALF) begin
                    for (int j = i + 1; j < 4; j++) pt[j] += TURN_FULL;
                end
            end
        end
        if (r.linear) begin
            d   = clip_acc(pt[2] - pt[1]);
            val = pt[1] + scale_t(d, tt);
            tng = d;
        end else begin
            c0 = clip_acc(shift_round(s * (pt[2] - pt[0]), csp_pkg::TEN_FB));
            c1 = clip_acc(shift_round(2 * s * pt[0] + (s - 3 * UNIT_TEN) * pt[1]
                                      + (3 * UNIT_TEN - 2 * s) * pt[2] - s * pt[3],
                                      csp_pkg::TEN_FB));
            c2 = clip_acc(shift_round(-s * pt[0] + (2 * UNIT_TEN - s) * pt[1]
                                      + (s - 2 * UNIT_TEN) * pt[2] + s * pt[3],
                                      csp_pkg::TEN_FB));
            acc = clip_acc(scale_t(c2, tt) + c1);
            acc = clip_acc(scale_t(acc, tt) + c0);
            val = scale_t(acc, tt) + pt[1];
            acc = clip_acc(3 * c2);
            acc = clip_acc(scale_t(acc, tt) + 2 * c1);
            tng = scale_t(acc, tt) + c0;
        end
        res.value   = clip_out(val);
        res.tangent = clip_out(tng);
        return res;
    endfunction

    function automatic sample_req_t random_sample();
        sample_req_t        r;
        int unsigned        mode;
        logic signed [31:0] base;
        logic signed [31:0] pts [4];
        mode = $urandom_range(0, 9);
        base = $urandom();
        pts[0] = $urandom();
        for (int i = 0; i < 4; i++) begin
            case (mode)
                0, 1, 2, 3: begin
                    base = base + (int'($urandom_range(0, 32'h10_0000)) - 32'sh8_0000);
                    pts[i] = base;
                end
                4, 5: begin
                    pts[i] = $urandom();
                end
                6, 7: begin
                    pts[i] = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                              ^ 16'($urandom_range(0, 3)), 16'($urandom())};
                end
                8: begin
                    case ($urandom_range(0, 3))
                        0: pts[i] = PT_MAX;
                        1: pts[i] = PT_MIN;
                        2: pts[i] = '0;
                        default: pts[i] = '1;
                    endcase
                end
                default: begin
                    if (i > 0) begin
                        pts[i] = pts[i-1] + PT_MIN + 32'($urandom_range(0, 2)) - 32'd1;
                    end
                end
            endcase
        end
        r.prev_pt  = pts[0];
        r.cur_pt   = pts[1];
        r.next_pt  = pts[2];
        r.after_pt = pts[3];
        case ($urandom_range(0, 9))
            0: r.t = 17'd0;
            1: r.t = 17'd65536;
            2: r.t = 17'($urandom_range(65537, 131071));
            default: r.t = 17'($urandom_range(0, 65535));
        endcase
        r.linear = ($urandom_range(0, 3) == 0);
        if (mode >= 6) begin
            r.angle_wrap = ($urandom_range(0, 4) != 0);
        end else begin
            r.angle_wrap = ($urandom_range(0, 3) == 0);
        end
        return r;
    endfunction

    task automatic queue_sample(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] d,
                                input logic [16:0] t, input logic lin, input logic wrap);
        sample_req_t r;
        r.prev_pt    = a;
        r.cur_pt     = b;
        r.next_pt    = c;
        r.after_pt   = d;
        r.t          = t;
        r.linear     = lin;
        r.angle_wrap = wrap;
        pending_samples.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t ERROR %s: expected %h, got %h", $time, what, want, got);
        err_count++;
    endtask

    task automatic apb_access(input logic wr, input logic [csp_pkg::APB_AW-1:0] addr,
                              input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (wr) begin
            if (addr[csp_pkg::APB_AW-1:csp_pkg::REG_IDX_LSB] == csp_pkg::REG_TENSION) begin
                tension_model = data[15:0];
            end
        end else if (prdata !== {16'd0, tension_model}) begin
            report_mismatch("tension readback", {48'd0, tension_model}, {32'd0, prdata});
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_curve.size() != 0);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    always @(negedge aclk) begin : drive_proc
        sample_req_t r;
        if (aresetn && (!s_tvalid || req_taken)) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                r = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(csp_pkg::IN_TDATA_W - 145){1'b0}}, r.t, r.after_pt,
                             r.next_pt, r.cur_pt, r.prev_pt};
                s_tuser  <= {r.angle_wrap, r.linear};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin : watch_proc
        spline_res_t want;
        sample_req_t r;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (expected_curve.size() == 0) begin
                    report_mismatch("unexpected result", 64'd0, m_tdata[63:0]);
                end else begin
                    want = expected_curve.pop_front();
                    if (m_tdata[39:0] !== want.value) begin
                        report_mismatch("value", {24'd0, want.value}, {24'd0, m_tdata[39:0]});
                    end
                    if (m_tdata[79:40] !== want.tangent) begin
                        report_mismatch("tangent", {24'd0, want.tangent},
                                        {24'd0, m_tdata[79:40]});
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                r.prev_pt    = s_tdata[31:0];
                r.cur_pt     = s_tdata[63:32];
                r.next_pt    = s_tdata[95:64];
                r.after_pt   = s_tdata[127:96];
                r.t          = s_tdata[144:128];
                r.linear     = s_tuser[csp_pkg::USER_LINEAR];
                r.angle_wrap = s_tuser[csp_pkg::USER_WRAP];
                expected_curve.push_back(eval_segment(r, tension_model));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph / 2)
                0: begin
                    send_idle = 6;
                    recv_idle = 49;
                end
                1: begin
                    send_idle = 49;
                    recv_idle = 6;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (ph)
                0: ;
                1: apb_access(1'b1, ADDR_TENSION, 32'd0);
                2: apb_access(1'b1, ADDR_TENSION, 32'd65535);
                3: begin
                    apb_access(1'b1, ADDR_TENSION, 32'($urandom_range(1, 65534)));
                    apb_access(1'b1, ADDR_UNMAPPED, $urandom());
                end
                4: apb_access(1'b1, ADDR_TENSION, 32'd32768);
                default: apb_access(1'b1, ADDR_TENSION, 32'($urandom_range(0, 65535)));
            endcase
            apb_access(1'b0, ADDR_TENSION, 32'd0);
            if (ph == 0) begin
                queue_sample(0, 0, 0, 0, 17'd0, 1'b0, 1'b0);
                queue_sample(PT_MAX, PT_MAX, PT_MAX, PT_MAX, 17'd65536, 1'b0, 1'b0);
                queue_sample(PT_MIN, PT_MIN, PT_MIN, PT_MIN, 17'd131071, 1'b0, 1'b0);
                queue_sample(PT_MAX, PT_MIN, PT_MAX, PT_MIN, 17'd131071, 1'b0, 1'b0);
                queue_sample(PT_MIN, PT_MAX, PT_MIN, PT_MAX, 17'd131071, 1'b0, 1'b0);
                queue_sample(PT_MIN, PT_MAX, PT_MIN, PT_MAX, 17'd131071, 1'b1, 1'b0);
                queue_sample(0, PT_MIN, PT_MAX, 0, 17'd65536, 1'b1, 1'b0);
                queue_sample(5, 32'h0001_0000, 32'h0003_0000, 7, 17'd0, 1'b1, 1'b0);
                queue_sample(0, 32'h0001_0000, 32'h0003_0000, 0, 17'd32768, 1'b1, 1'b0);
                queue_sample(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000,
                             17'd1, 1'b0, 1'b0);
                queue_sample(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000,
                             17'd65535, 1'b0, 1'b0);
                queue_sample(0, PT_MIN, 0, PT_MAX, 17'd32768, 1'b0, 1'b1);
                queue_sample(1, PT_MIN, PT_MAX, PT_MIN, 17'd49152, 1'b0, 1'b1);
                queue_sample(PT_MIN, PT_MAX, PT_MIN, PT_MAX, 17'd131071, 1'b0, 1'b1);
                queue_sample(32'h7FFF_0000, 32'h7FFF_0000, 32'h8001_0000, 32'h8001_0000,
                             17'd16384, 1'b1, 1'b1);
                queue_sample(32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_0000, 32'h8001_0000,
                             17'd65536, 1'b1, 1'b1);
                queue_sample(32'h4000_0000, 32'hC000_0000, 32'h4000_0000, 32'hC000_0001,
                             17'd98304, 1'b0, 1'b1);
                queue_sample(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 17'd65536, 1'b0, 1'b0);
                queue_sample(PT_MAX, PT_MAX, PT_MIN, PT_MIN, 17'd131071, 1'b1, 1'b1);
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                pending_samples.push_back(random_sample());
            end
        end
        wait_idle();
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
